// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define BAL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define BAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bal_pkg.sv =====
// Types and constants of the bounded array list.
package bal_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;

	localparam int KIND_W   = 4;
	localparam int POS_W    = 8;
	localparam int VALUE_W  = 32;
	localparam int CAP_W    = 9;
	localparam int COUNT_W  = 9;
	localparam int STATUS_W = 2;

	localparam int CNT_IW = $clog2(DEPTH + 1);
	localparam int CW     = (CNT_IW > CAP_W) ? CNT_IW : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	localparam int GRP_SZ = 16;
	localparam int NGRP   = (DEPTH + GRP_SZ - 1) / GRP_SZ;

	typedef enum logic [KIND_W-1:0] {
		KIND_GET        = 4'd0,
		KIND_SET        = 4'd1,
		KIND_INSERT     = 4'd2,
		KIND_REMOVE     = 4'd3,
		KIND_APPEND     = 4'd4,
		KIND_PUSH_FRONT = 4'd5,
		KIND_POP_BACK   = 4'd6,
		KIND_TAKE_FRONT = 4'd7,
		KIND_CLEAR      = 4'd8
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_SET  = 2'd1,
		CELL_INS  = 2'd2,
		CELL_DEL  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [CW-1:0]         pos;
		logic                  rd_en;
		logic [CW-1:0]         rd_pos;
		logic [DATA_WIDTH-1:0] wdata;
	} cell_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_GATHER = 4'b0100,
		S_OUT    = 4'b1000
	} state_t;

endpackage

// ===== rtl/bal_if.sv =====
// Request and response channel interfaces of the bounded array list.
interface bal_req_if;
	logic                        valid;
	logic                        ready;
	logic [bal_pkg::KIND_W-1:0]  kind;
	logic [bal_pkg::POS_W-1:0]   position;
	logic [bal_pkg::VALUE_W-1:0] value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

interface bal_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bal_pkg::VALUE_W-1:0]  read_value;
	logic [bal_pkg::STATUS_W-1:0] status;
	logic [bal_pkg::COUNT_W-1:0]  count;
	logic                         is_empty;

	modport source (output valid, read_value, status, count, is_empty, input ready);
	modport sink   (input valid, read_value, status, count, is_empty, output ready);
endinterface

// ===== rtl/bal_cell.sv =====
// One list entry: holds a word, shifts to or from its neighbors, drives its read tap.
module bal_cell (
	input  logic                           clk,
	input  logic [bal_pkg::CW-1:0]         idx,
	input  bal_pkg::cell_cmd_t             cmd,
	input  logic [bal_pkg::DATA_WIDTH-1:0] below,
	input  logic [bal_pkg::DATA_WIDTH-1:0] above,
	output logic [bal_pkg::DATA_WIDTH-1:0] data,
	output logic [bal_pkg::DATA_WIDTH-1:0] rd
);
	import bal_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_SET: begin
				if (idx == cmd.pos) data_q <= cmd.wdata;
			end
			CELL_INS: begin
				if (idx > cmd.pos) data_q <= below;
				else if (idx == cmd.pos) data_q <= cmd.wdata;
			end
			CELL_DEL: begin
				if (idx >= cmd.pos) data_q <= above;
			end
			default: ;
		endcase
	end

	assign data = data_q;
	assign rd   = (cmd.rd_en && idx == cmd.rd_pos) ? data_q : '0;

endmodule

// ===== rtl/bounded_array_list.sv =====
// Top level of the bounded array list: control, entry cell chain and read gather.
//
// Requests arrive on req (kind, position, value) with a valid/ready handshake;
// one response per request leaves on rsp (read_value, status, count, is_empty).
// The capacity register is written through cfg_we/cfg_wdata; the user must do
// so only while idle, the block does not enforce it. Entries live in a chain
// of cells, one per entry; insert and push move all later entries up one cell
// in the execute state, remove and pop front move them down, so every operation
// costs the same regardless of position.
// The response passes through the execute state, the gather of the read taps
// in groups of 16 and the output register before it is valid. One request at
// a time; req.ready is high only when idle.
// A stalled receiver holds the response in the output register and the
// block takes no new request until it is taken.
// Reset clears the entry count to zero and sets the capacity to 256; entry
// contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module bounded_array_list (
	input  logic                      clk,
	input  logic                      arst_n,
	bal_req_if.sink                   req,
	bal_rsp_if.source                 rsp,
	input  logic                      cfg_we,
	input  logic [bal_pkg::CAP_W-1:0] cfg_wdata
);
	import bal_pkg::*;

	state_t                state_q;
	logic [CAP_W-1:0]      cap_q;
	logic [CNT_IW-1:0]     count_q;
	logic [KIND_W-1:0]     kind_q;
	logic [POS_W-1:0]      pos_q;
	logic [VALUE_W-1:0]    value_q;

	cell_cmd_t             cmd;
	status_t               st;
	logic [CNT_IW-1:0]     nxt_cnt;
	logic [CW-1:0]         cnt_c;
	logic [CW-1:0]         pos_c;
	logic [CW-1:0]         eff_cap;
	logic                  full;

	logic [DATA_WIDTH-1:0] data_cell [DEPTH];
	logic [DATA_WIDTH-1:0] rd_cell   [DEPTH];
	logic [DATA_WIDTH-1:0] grp_d     [NGRP];
	logic [DATA_WIDTH-1:0] grp_s1    [NGRP];
	logic [DATA_WIDTH-1:0] gather;

	status_t               st_s1;
	logic [CNT_IW-1:0]     cnt_s1;
	logic [VALUE_W-1:0]    rd_value_q;
	status_t               status_q;
	logic [CNT_IW-1:0]     cnt_out_q;

	logic                  req_fire;
	logic                  rsp_fire;

	assign req_fire = req.valid && req.ready;
	assign rsp_fire = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q   <= CAP_RESET;
			count_q <= '0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE:   if (req_fire) state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= S_GATHER;
					count_q <= nxt_cnt;
				end
				S_GATHER: state_q <= S_OUT;
				S_OUT:    if (rsp_fire) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q  <= req.kind;
			pos_q   <= req.position;
			value_q <= req.value;
		end
	end

	// request decode against the current count and capacity
	always_comb begin
		cnt_c   = CW'(count_q);
		pos_c   = CW'(pos_q);
		eff_cap = (CW'(cap_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
		full    = cnt_c >= eff_cap;

		st          = ST_OK;
		nxt_cnt     = count_q;
		cmd.op      = CELL_HOLD;
		cmd.pos     = pos_c;
		cmd.rd_en   = 1'b0;
		cmd.rd_pos  = pos_c;
		cmd.wdata   = DATA_WIDTH'(value_q);

		case (kind_q)
			KIND_GET: begin
				if (pos_c < cnt_c) cmd.rd_en = 1'b1;
				else st = ST_RANGE;
			end
			KIND_SET: begin
				if (pos_c < cnt_c) cmd.op = CELL_SET;
				else st = ST_RANGE;
			end
			KIND_INSERT: begin
				if (full) st = ST_FULL;
				else if (pos_c > cnt_c) st = ST_RANGE;
				else begin
					cmd.op  = CELL_INS;
					nxt_cnt = count_q + CNT_IW'(1);
				end
			end
			KIND_REMOVE: begin
				if (pos_c < cnt_c) begin
					cmd.op  = CELL_DEL;
					nxt_cnt = count_q - CNT_IW'(1);
				end else st = ST_RANGE;
			end
			KIND_APPEND: begin
				if (full) st = ST_FULL;
				else begin
					cmd.op  = CELL_INS;
					cmd.pos = cnt_c;
					nxt_cnt = count_q + CNT_IW'(1);
				end
			end
			KIND_PUSH_FRONT: begin
				if (full) st = ST_FULL;
				else begin
					cmd.op  = CELL_INS;
					cmd.pos = '0;
					nxt_cnt = count_q + CNT_IW'(1);
				end
			end
			KIND_POP_BACK: begin
				if (count_q == '0) st = ST_EMPTY;
				else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_pos = cnt_c - CW'(1);
					nxt_cnt    = count_q - CNT_IW'(1);
				end
			end
			KIND_TAKE_FRONT: begin
				if (count_q == '0) st = ST_EMPTY;
				else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_pos = '0;
					cmd.op     = CELL_DEL;
					cmd.pos    = '0;
					nxt_cnt    = count_q - CNT_IW'(1);
				end
			end
			KIND_CLEAR: nxt_cnt = '0;
			default: ;
		endcase

		if (state_q != S_EXEC) begin
			cmd.op    = CELL_HOLD;
			cmd.rd_en = 1'b0;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] below;
		logic [DATA_WIDTH-1:0] above;
		if (i == 0) begin : g_first
			assign below = '0;
		end else begin : g_mid
			assign below = data_cell[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign above = '0;
		end else begin : g_inner
			assign above = data_cell[i+1];
		end
		bal_cell u_cell (
			.clk   (clk),
			.idx   (CW'(i)),
			.cmd   (cmd),
			.below (below),
			.above (above),
			.data  (data_cell[i]),
			.rd    (rd_cell[i])
		);
	end

	// read taps are zero except the addressed cell: OR in groups, then across groups
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP_SZ; j++) begin
				if (g * GRP_SZ + j < DEPTH) grp_d[g] = grp_d[g] | rd_cell[g * GRP_SZ + j];
			end
		end
	end

	always_comb begin
		gather = '0;
		for (int g = 0; g < NGRP; g++) gather = gather | grp_s1[g];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			grp_s1 <= grp_d;
			st_s1  <= st;
			cnt_s1 <= nxt_cnt;
		end
		if (state_q == S_GATHER) begin
			rd_value_q <= VALUE_W'(gather);
			status_q   <= st_s1;
			cnt_out_q  <= cnt_s1;
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = (state_q == S_OUT);
	assign rsp.read_value = rd_value_q;
	assign rsp.status     = status_q;
	assign rsp.count      = COUNT_W'(cnt_out_q);
	assign rsp.is_empty   = (cnt_out_q == '0);

	`BAL_ASSERT(a_count_bound, count_q <= CNT_IW'(DEPTH), "entry count above depth")
	`BAL_ASSERT(a_one_in_flight, !(req.ready && rsp.valid), "request taken while busy")
	`BAL_ASSERT_NEXT(a_accept_exec, req_fire, state_q == S_EXEC, "accepted item not executed")
	`BAL_ASSERT_NEXT(a_ins_grows, state_q == S_EXEC && cmd.op == CELL_INS, count_q == $past(count_q) + CNT_IW'(1), "insert no grow")

endmodule

// ===== tb/bounded_array_list_test.sv =====
// Self-checking testbench for the bounded array list: directed and random requests.
module bounded_array_list_test;
	import bal_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int AWAIT_DEPTH = 16;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		status_t            status;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} list_resp_t;

	class list_scoreboard;
		logic [DATA_WIDTH-1:0] entries [DEPTH];
		int unsigned used;
		int unsigned cap_reg;
		list_resp_t awaited [AWAIT_DEPTH];
		int unsigned aw_head;
		int unsigned aw_tail;
		int unsigned aw_fill;
		int unsigned mismatches;
		int unsigned requests;
		int unsigned peak;
		int unsigned status_seen [4];

		function new();
			used = 0;
			cap_reg = CAP_RESET;
			aw_head = 0;
			aw_tail = 0;
			aw_fill = 0;
			mismatches = 0;
			requests = 0;
			peak = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			cap_reg = c;
		endfunction

		function status_t place(int unsigned at, logic [DATA_WIDTH-1:0] w);
			int unsigned lim;
			lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
			if (used >= lim)
				return ST_FULL;
			if (at > used)
				return ST_RANGE;
			for (int unsigned i = used; i > at; i--)
				entries[i] = entries[i - 1];
			entries[at] = w;
			used++;
			return ST_OK;
		endfunction

		function void take_out(int unsigned at);
			for (int unsigned i = at; i + 1 < used; i++)
				entries[i] = entries[i + 1];
			used--;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
				logic [VALUE_W-1:0] val);
			list_resp_t exp;
			exp.read_value = '0;
			exp.status = ST_OK;
			case (kind)
				KIND_GET: begin
					if (pos < used)
						exp.read_value = VALUE_W'(entries[pos]);
					else
						exp.status = ST_RANGE;
				end
				KIND_SET: begin
					if (pos < used)
						entries[pos] = DATA_WIDTH'(val);
					else
						exp.status = ST_RANGE;
				end
				KIND_INSERT:     exp.status = place(pos, DATA_WIDTH'(val));
				KIND_REMOVE: begin
					if (pos < used)
						take_out(pos);
					else
						exp.status = ST_RANGE;
				end
				KIND_APPEND:     exp.status = place(used, DATA_WIDTH'(val));
				KIND_PUSH_FRONT: exp.status = place(0, DATA_WIDTH'(val));
				KIND_POP_BACK: begin
					if (used == 0) begin
						exp.status = ST_EMPTY;
					end else begin
						exp.read_value = VALUE_W'(entries[used - 1]);
						used--;
					end
				end
				KIND_TAKE_FRONT: begin
					if (used == 0) begin
						exp.status = ST_EMPTY;
					end else begin
						exp.read_value = VALUE_W'(entries[0]);
						take_out(0);
					end
				end
				KIND_CLEAR:      used = 0;
				default: ;
			endcase
			exp.count = COUNT_W'(used);
			exp.is_empty = (used == 0);
			if (aw_fill < AWAIT_DEPTH) begin
				awaited[aw_tail] = exp;
				aw_tail = (aw_tail + 1) % AWAIT_DEPTH;
				aw_fill++;
			end else begin
				mismatches++;
			end
			status_seen[exp.status]++;
			requests++;
			if (used > peak)
				peak = used;
		endfunction

		function void check_response(list_resp_t got);
			list_resp_t exp;
			if (aw_fill == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response rd=%h st=%0d cnt=%0d empty=%b",
						got.read_value, got.status, got.count, got.is_empty);
				return;
			end
			exp = awaited[aw_head];
			aw_head = (aw_head + 1) % AWAIT_DEPTH;
			aw_fill--;
			if (got.read_value !== exp.read_value || got.status !== exp.status ||
					got.count !== exp.count || got.is_empty !== exp.is_empty) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %h/%0d/%0d/%b got %h/%0d/%0d/%b",
						exp.read_value, exp.status, exp.count, exp.is_empty,
						got.read_value, got.status, got.count, got.is_empty);
			end
		endfunction

		function int unsigned pending();
			return aw_fill;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	int unsigned src_idle_pct = 36;
	int unsigned snk_idle_pct = 49;
	int unsigned stall_len = 0;
	int unsigned cap_settings = 0;

	list_scoreboard sb = new();

	bal_req_if req_ch ();
	bal_rsp_if rsp_ch ();

	bounded_array_list uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// response side: random back-pressure plus long hold-offs on request
	initial begin
		int unsigned stall_left;
		list_resp_t got;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_len != 0) begin
				stall_left = stall_len;
				stall_len = 0;
			end
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.read_value = rsp_ch.read_value;
				got.status = status_t'(rsp_ch.status);
				got.count = rsp_ch.count;
				got.is_empty = rsp_ch.is_empty;
				sb.check_response(got);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("bounded_array_list_test: done, errors");
		$finish;
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_request(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
			logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.position <= p;
		req_ch.value <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(k, p, v);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(c);
		cap_settings++;
	endtask

	task automatic random_burst(int unsigned n, int unsigned grow_pct);
		logic [KIND_W-1:0] k;
		logic [POS_W-1:0] p;
		logic [VALUE_W-1:0] v;
		int unsigned r;
		int unsigned top;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) < grow_pct) begin
				case ($urandom_range(2))
					0:       k = KIND_INSERT;
					1:       k = KIND_APPEND;
					default: k = KIND_PUSH_FRONT;
				endcase
			end else begin
				r = $urandom_range(99);
				if (r < 2 && grow_pct < 60) begin
					k = KIND_CLEAR;
				end else if (r < 4) begin
					k = KIND_W'($urandom_range(15, 9));
				end else begin
					case ($urandom_range(4))
						0:       k = KIND_GET;
						1:       k = KIND_SET;
						2:       k = KIND_REMOVE;
						3:       k = KIND_POP_BACK;
						default: k = KIND_TAKE_FRONT;
					endcase
				end
			end
			top = (sb.used > 255) ? 255 : sb.used;
			if ($urandom_range(99) < 80)
				p = POS_W'($urandom_range(top));
			else
				p = POS_W'($urandom_range(255));
			case ($urandom_range(9))
				0:       v = '0;
				1:       v = '1;
				default: v = $urandom;
			endcase
			send_request(k, p, v);
		end
	endtask

	task automatic run_phase(logic [CAP_W-1:0] c, int unsigned grow_pct, int unsigned n);
		wait_idle();
		write_capacity(c);
		random_burst(n, grow_pct);
	endtask

	initial begin
		int unsigned errors;
		req_ch.valid = 1'b0;
		req_ch.kind = '0;
		req_ch.position = '0;
		req_ch.value = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list, reset capacity
		send_request(KIND_GET, 8'd0, 32'h0);
		send_request(KIND_REMOVE, 8'd255, 32'h0);
		send_request(KIND_POP_BACK, 8'd0, 32'h0);
		send_request(KIND_TAKE_FRONT, 8'd0, 32'h0);
		send_request(KIND_INSERT, 8'd1, 32'h1234_5678);
		send_request(KIND_INSERT, 8'd0, 32'hffff_ffff);
		send_request(KIND_PUSH_FRONT, 8'd77, 32'h0);
		send_request(KIND_APPEND, 8'd0, 32'h8000_0001);
		send_request(KIND_INSERT, 8'd3, 32'h5a5a_a5a5);
		send_request(KIND_SET, 8'd1, 32'h7fff_fffe);
		send_request(KIND_SET, 8'd4, 32'h1);
		send_request(KIND_GET, 8'd1, 32'h0);
		send_request(KIND_GET, 8'd255, 32'h0);
		send_request(4'd9, 8'd0, 32'h0);
		send_request(4'd15, 8'd255, 32'hffff_ffff);
		send_request(KIND_REMOVE, 8'd0, 32'h0);
		send_request(KIND_TAKE_FRONT, 8'd0, 32'h0);
		send_request(KIND_CLEAR, 8'd0, 32'h0);

		// full before position check
		wait_idle();
		write_capacity(9'd2);
		send_request(KIND_APPEND, 8'd0, 32'hdead_beef);
		send_request(KIND_APPEND, 8'd0, 32'h0000_0001);
		send_request(KIND_INSERT, 8'd255, 32'h2);
		send_request(KIND_PUSH_FRONT, 8'd0, 32'h3);

		// capacity dropped under the count
		wait_idle();
		write_capacity(9'd0);
		send_request(KIND_APPEND, 8'd0, 32'h4);
		send_request(KIND_POP_BACK, 8'd0, 32'h0);
		send_request(KIND_TAKE_FRONT, 8'd0, 32'h0);
		send_request(KIND_INSERT, 8'd0, 32'h5);

		run_phase(9'd256, 85, 350);
		wait_idle();
		stall_len = 200;
		random_burst(300, 30);

		src_idle_pct = 49;
		snk_idle_pct = 36;
		run_phase(9'd1, 50, 150);
		run_phase(9'd8, 55, 250);
		run_phase(9'd511, 85, 400);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		wait_idle();
		write_capacity(9'd40);
		stall_len = 150;
		random_burst(250, 40);
		run_phase(9'd0, 50, 50);
		run_phase(9'd129, 50, 200);

		wait_idle();
		errors = sb.mismatches + sb.pending();
		$display("run covered %0d requests over %0d capacity settings, peak count %0d",
			sb.requests, cap_settings, sb.peak);
		$display("statuses seen: ok %0d, out of range %0d, full %0d, empty %0d",
			sb.status_seen[ST_OK], sb.status_seen[ST_RANGE],
			sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY]);
		if (errors == 0)
			$display("bounded_array_list_test: done, clean");
		else
			$display("bounded_array_list_test: done, errors");
		$finish;
	end

endmodule
